// ===== hdl/prplb_pkg.sv =====
// prplb_pkg: shared types and constants of the prp list builder
// result kind codes, controller/datapath command and status structs
// no dependencies
`default_nettype none

package prplb_pkg;

    // field widths fixed by the interface
    localparam int ADDR_W        = 48;
    localparam int LEN_W         = 18;
    localparam int SHIFT_W       = 5;
    localparam int KIND_W        = 2;

    // page shift range and reset value
    localparam logic [SHIFT_W-1:0] PAGE_SHIFT_MIN   = 5'd12;
    localparam logic [SHIFT_W-1:0] PAGE_SHIFT_MAX   = 5'd16;
    localparam logic [SHIFT_W-1:0] PAGE_SHIFT_RESET = 5'd12;

    // largest page in bytes needs this many bits
    localparam int PAGE_W        = 17;

    // parameter defaults
    localparam int MAX_LIST_ENTRIES_DEF = 63;
    localparam int ADDRESS_BITS_DEF     = 48;

    typedef enum logic [KIND_W-1:0] {
        KIND_ENTRY = 2'd0,
        KIND_FINAL = 2'd1,
        KIND_ERROR = 2'd2
    } t_kind;

    typedef struct packed {
        logic load;
        logic calc;
        logic emit_entry;
        logic emit_final;
    } t_cmd;

    typedef struct packed {
        logic out_free;
        logic list_mode;
        logic one_left;
    } t_status;

endpackage

`default_nettype wire

// ===== hdl/prp_list_builder.sv =====
// prp_list_builder: top level of the nvme prp pointer and list builder
// instantiates prplb_ctrl and prplb_dp, uses prplb_pkg
//
// usage
//   input channel (i_in_valid / o_in_ready): one item per host buffer, carrying
//   its byte address, byte length and the address of the list page
//   output channel (o_out_valid / i_out_ready): result items; a long buffer gives
//   one list entry write per further page, then a final item with last set
//   config channel (i_cfg_valid / o_cfg_ready): page shift, always ready, write
//   only while the block is idle; values below 12 act as 12, above 16 as 16
// timing
//   one item at a time: accept, page math, then one result per cycle from the
//   output register while the receiver takes them; the entry loop advances the
//   running slot and page address adders in the datapath
//   a short, empty or overlong buffer skips the entry loop and gives only its
//   final item
// reset
//   synchronous active low; clears the state machine and the output valid,
//   page shift returns to 12
// stall
//   the output register holds its item until taken; the entry loop waits on it
`default_nettype none

module prp_list_builder #(
    parameter int MAX_LIST_ENTRIES = prplb_pkg::MAX_LIST_ENTRIES_DEF,
    parameter int ADDRESS_BITS     = prplb_pkg::ADDRESS_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // configuration
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [prplb_pkg::SHIFT_W-1:0] i_cfg_page_shift,
    // input items
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [prplb_pkg::ADDR_W-1:0]  i_buffer_address,
    input  wire logic [prplb_pkg::LEN_W-1:0]   i_length_bytes,
    input  wire logic [prplb_pkg::ADDR_W-1:0]  i_list_page_address,
    // result items
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic [prplb_pkg::KIND_W-1:0]       o_kind,
    output logic [prplb_pkg::ADDR_W-1:0]       o_entry_address,
    output logic [prplb_pkg::ADDR_W-1:0]       o_entry_value,
    output logic [prplb_pkg::ADDR_W-1:0]       o_first_pointer,
    output logic [prplb_pkg::ADDR_W-1:0]       o_second_pointer,
    output logic                               o_last
);

    prplb_pkg::t_cmd    cmd;
    prplb_pkg::t_status status;

    // the shift register takes a write in any cycle
    assign o_cfg_ready = 1'b1;

    // sequencing: idle, page math, entry loop, final item
    prplb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // page math, slot and page address counters, output register
    prplb_dp #(
        .MAX_LIST_ENTRIES (MAX_LIST_ENTRIES),
        .ADDRESS_BITS     (ADDRESS_BITS)
    ) u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_valid         (i_cfg_valid),
        .i_cfg_page_shift    (i_cfg_page_shift),
        .i_buffer_address    (i_buffer_address),
        .i_length_bytes      (i_length_bytes),
        .i_list_page_address (i_list_page_address),
        .i_cmd               (cmd),
        .o_status            (status),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_kind              (o_kind),
        .o_entry_address     (o_entry_address),
        .o_entry_value       (o_entry_value),
        .o_first_pointer     (o_first_pointer),
        .o_second_pointer    (o_second_pointer),
        .o_last              (o_last)
    );

endmodule

`default_nettype wire

// ===== hdl/prplb_ctrl.sv =====
// prplb_ctrl: sequencing state machine of the prp list builder
// depends on prplb_pkg (t_cmd, t_status)
`default_nettype none

module prplb_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire prplb_pkg::t_status i_status,
    output prplb_pkg::t_cmd        o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CALC,
        S_ENTRY,
        S_FINAL
    } t_state;

    t_state r_state;

    always_comb begin
        o_cmd            = '0;
        o_cmd.load       = (r_state == S_IDLE) && i_in_valid;
        o_cmd.calc       = (r_state == S_CALC);
        o_cmd.emit_entry = (r_state == S_ENTRY) && i_status.list_mode && i_status.out_free;
        o_cmd.emit_final = (r_state == S_FINAL) && i_status.out_free;
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_CALC;
                    end
                end
                S_CALC: begin
                    r_state <= S_ENTRY;
                end
                S_ENTRY: begin
                    // short, empty and overlong buffers go straight to the final item
                    if (!i_status.list_mode) begin
                        r_state <= S_FINAL;
                    end else if (i_status.out_free && i_status.one_left) begin
                        r_state <= S_FINAL;
                    end
                end
                S_FINAL: begin
                    if (i_status.out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== hdl/prplb_dp.sv =====
// prplb_dp: datapath of the prp list builder
// holds the page shift register, item registers, address counters and output register
// depends on prplb_pkg
`default_nettype none

module prplb_dp #(
    parameter int MAX_LIST_ENTRIES = prplb_pkg::MAX_LIST_ENTRIES_DEF,
    parameter int ADDRESS_BITS     = prplb_pkg::ADDRESS_BITS_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_valid,
    input  wire logic [prplb_pkg::SHIFT_W-1:0]      i_cfg_page_shift,
    input  wire logic [prplb_pkg::ADDR_W-1:0]       i_buffer_address,
    input  wire logic [prplb_pkg::LEN_W-1:0]        i_length_bytes,
    input  wire logic [prplb_pkg::ADDR_W-1:0]       i_list_page_address,
    input  wire prplb_pkg::t_cmd                    i_cmd,
    output prplb_pkg::t_status                      o_status,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_ready,
    output logic [prplb_pkg::KIND_W-1:0]            o_kind,
    output logic [prplb_pkg::ADDR_W-1:0]            o_entry_address,
    output logic [prplb_pkg::ADDR_W-1:0]            o_entry_value,
    output logic [prplb_pkg::ADDR_W-1:0]            o_first_pointer,
    output logic [prplb_pkg::ADDR_W-1:0]            o_second_pointer,
    output logic                                    o_last
);

    localparam int AW      = prplb_pkg::ADDR_W;
    localparam int PW      = prplb_pkg::PAGE_W;
    localparam int SUM_W   = prplb_pkg::LEN_W + 1;
    localparam int CNT_W   = 7;
    localparam int ENTRY_W = $clog2(MAX_LIST_ENTRIES + 1);

    localparam logic [63:0] MASK64 = (ADDRESS_BITS >= 64) ? {64{1'b1}}
                                   : ((64'd1 << ADDRESS_BITS) - 64'd1);
    localparam logic [AW-1:0] ADDR_MASK = MASK64[AW-1:0];

    // configuration and item registers
    logic [prplb_pkg::SHIFT_W-1:0] r_cfg_shift;
    logic [prplb_pkg::SHIFT_W-1:0] r_sh;
    logic [AW-1:0]                 r_buf;
    logic [prplb_pkg::LEN_W-1:0]   r_len;
    logic [AW-1:0]                 r_list;

    // run state
    logic [AW-1:0]                 r_slot;
    logic [AW-1:0]                 r_val;
    logic [ENTRY_W-1:0]            r_remaining;
    logic                          r_list_mode;
    prplb_pkg::t_kind              r_fin_kind;
    logic [AW-1:0]                 r_fin_first;
    logic [AW-1:0]                 r_fin_second;

    // output register
    logic                          r_out_valid;
    prplb_pkg::t_kind              r_kind;
    logic [AW-1:0]                 r_ea;
    logic [AW-1:0]                 r_ev;
    logic [AW-1:0]                 r_fp;
    logic [AW-1:0]                 r_sp;
    logic                          r_last;

    logic [prplb_pkg::SHIFT_W-1:0] n_sh;
    logic [PW-1:0]                 page;
    logic [15:0]                   offset;
    logic [PW-1:0]                 first_len;
    logic                          fits;
    logic [SUM_W-1:0]              rest;
    logic [CNT_W-1:0]              entries;
    logic                          too_long;
    logic [AW-1:0]                 first_next;
    logic                          out_free;

    always_comb begin
        if (r_cfg_shift < prplb_pkg::PAGE_SHIFT_MIN) begin
            n_sh = prplb_pkg::PAGE_SHIFT_MIN;
        end else if (r_cfg_shift > prplb_pkg::PAGE_SHIFT_MAX) begin
            n_sh = prplb_pkg::PAGE_SHIFT_MAX;
        end else begin
            n_sh = r_cfg_shift;
        end
    end

    always_comb begin
        page       = PW'(1) << r_sh;
        offset     = r_buf[15:0] & 16'(page - PW'(1));
        first_len  = page - {1'b0, offset};
        fits       = (SUM_W'(offset) + SUM_W'(r_len)) <= (SUM_W'(page) << 1);
        rest       = SUM_W'(r_len) - SUM_W'(first_len);
        entries    = CNT_W'((rest + SUM_W'(page) - SUM_W'(1)) >> r_sh);
        too_long   = entries > CNT_W'(MAX_LIST_ENTRIES);
        first_next = (r_buf + AW'(first_len)) & ADDR_MASK;
    end

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        o_status           = '0;
        o_status.out_free  = out_free;
        o_status.list_mode = r_list_mode;
        o_status.one_left  = (r_remaining == ENTRY_W'(1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_shift <= prplb_pkg::PAGE_SHIFT_RESET;
        end else if (i_cfg_valid) begin
            r_cfg_shift <= i_cfg_page_shift;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_buf  <= i_buffer_address;
            r_len  <= i_length_bytes;
            r_list <= i_list_page_address;
            r_sh   <= n_sh;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_list_mode <= 1'b0;
        end else if (i_cmd.calc) begin
            r_val       <= first_next;
            r_slot      <= r_list & ADDR_MASK;
            r_remaining <= ENTRY_W'(entries);
            r_list_mode <= 1'b0;
            if (r_len == '0) begin
                r_fin_kind   <= prplb_pkg::KIND_FINAL;
                r_fin_first  <= '0;
                r_fin_second <= '0;
            end else if (fits) begin
                r_fin_kind   <= prplb_pkg::KIND_FINAL;
                r_fin_first  <= r_buf;
                r_fin_second <= (SUM_W'(r_len) > SUM_W'(first_len)) ? first_next : '0;
            end else if (too_long) begin
                r_fin_kind   <= prplb_pkg::KIND_ERROR;
                r_fin_first  <= '0;
                r_fin_second <= '0;
            end else begin
                r_fin_kind   <= prplb_pkg::KIND_FINAL;
                r_fin_first  <= r_buf;
                r_fin_second <= r_list;
                r_list_mode  <= 1'b1;
            end
        end else if (i_cmd.emit_entry) begin
            r_slot      <= (r_slot + AW'(8)) & ADDR_MASK;
            r_val       <= (r_val + AW'(page)) & ADDR_MASK;
            r_remaining <= r_remaining - ENTRY_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_entry || i_cmd.emit_final) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_entry) begin
            r_kind <= prplb_pkg::KIND_ENTRY;
            r_ea   <= r_slot;
            r_ev   <= r_val;
            r_fp   <= '0;
            r_sp   <= '0;
            r_last <= 1'b0;
        end else if (i_cmd.emit_final) begin
            r_kind <= r_fin_kind;
            r_ea   <= '0;
            r_ev   <= '0;
            r_fp   <= r_fin_first;
            r_sp   <= r_fin_second;
            r_last <= 1'b1;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_kind           = r_kind;
    assign o_entry_address  = r_ea;
    assign o_entry_value    = r_ev;
    assign o_first_pointer  = r_fp;
    assign o_second_pointer = r_sp;
    assign o_last           = r_last;

endmodule

`default_nettype wire

// ===== tb/prp_list_builder_tb.sv =====
// prp_list_builder_tb: self-checking testbench of the prp pointer and list builder
// drives buffers and page shift writes, predicts every result item, compares them
// depends on prplb_pkg and prp_list_builder
`default_nettype none

module prp_list_builder_tb;

    localparam int          RESET_CYCLES   = 11;
    localparam int          DRAIN_CYCLES   = 80;
    localparam int unsigned CYCLE_LIMIT    = 1_000_000;
    localparam int          ITEMS_PER_SHIFT = 48;        // random items per page shift
    localparam int          LEN_RANGE_MAX  = 258048;     // legal at any 4 KiB offset
    localparam int          LEN_FIELD_MAX  = 2**prplb_pkg::LEN_W - 1;
    localparam int          AW             = prplb_pkg::ADDR_W;
    localparam int          LW             = prplb_pkg::LEN_W;
    localparam int          SW             = prplb_pkg::SHIFT_W;

    // one expected result item, fields at the port widths
    typedef struct packed {
        prplb_pkg::t_kind  kind;
        logic [AW-1:0]     entry_address;
        logic [AW-1:0]     entry_value;
        logic [AW-1:0]     first_pointer;
        logic [AW-1:0]     second_pointer;
        logic              last;
    } t_prp_result;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic [SW-1:0]       i_cfg_page_shift;
    logic                i_in_valid;
    logic                o_in_ready;
    logic [AW-1:0]       i_buffer_address;
    logic [LW-1:0]       i_length_bytes;
    logic [AW-1:0]       i_list_page_address;
    logic                o_out_valid;
    logic                i_out_ready;
    logic [prplb_pkg::KIND_W-1:0] o_kind;
    logic [AW-1:0]       o_entry_address;
    logic [AW-1:0]       o_entry_value;
    logic [AW-1:0]       o_first_pointer;
    logic [AW-1:0]       o_second_pointer;
    logic                o_last;

    // testbench copy of the page shift register, as written
    logic [SW-1:0]       page_shift_reg = prplb_pkg::PAGE_SHIFT_RESET;
    // results predicted for accepted buffers, oldest first
    t_prp_result         prp_results_due[$];
    int                  errors        = 0;
    int unsigned         cycle_count   = 0;
    // idling odds in percent, per clock
    int                  send_gap_pct  = 0;
    int                  stall_pct     = 0;

    prp_list_builder dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_page_shift    (i_cfg_page_shift),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_buffer_address    (i_buffer_address),
        .i_length_bytes      (i_length_bytes),
        .i_list_page_address (i_list_page_address),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_kind              (o_kind),
        .o_entry_address     (o_entry_address),
        .o_entry_value       (o_entry_value),
        .o_first_pointer     (o_first_pointer),
        .o_second_pointer    (o_second_pointer),
        .o_last              (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // page shift as the block uses it, clamped to the supported range
    function automatic int unsigned effective_shift();
        if (page_shift_reg < prplb_pkg::PAGE_SHIFT_MIN) return 32'(prplb_pkg::PAGE_SHIFT_MIN);
        if (page_shift_reg > prplb_pkg::PAGE_SHIFT_MAX) return 32'(prplb_pkg::PAGE_SHIFT_MAX);
        return 32'(page_shift_reg);
    endfunction

    // append one expected item behind the ones already due
    function automatic void queue_result(input t_prp_result item);
        prp_results_due.insert(prp_results_due.size(), item);
    endfunction

    // queue the result items one buffer gives under the current page shift
    function automatic void predict_prp_results(input logic [AW-1:0] data_addr,
                                                input logic [LW-1:0] len,
                                                input logic [AW-1:0] list_addr);
        int unsigned   sh;
        logic [63:0]   page;
        logic [63:0]   offset;
        logic [63:0]   first_len;
        logic [63:0]   entries;
        t_prp_result   fin;
        t_prp_result   slot;
        sh        = effective_shift();
        page      = 64'd1 << sh;
        fin       = '0;
        fin.kind  = prplb_pkg::KIND_FINAL;
        fin.last  = 1'b1;
        // empty buffer: final item with both pointers zero
        if (len == 0) begin
            queue_result(fin);
            return;
        end
        offset    = data_addr & (page - 1);
        first_len = page - offset;
        // fits in two pages: no list, second pointer only when it spills over
        if (offset + len <= 2 * page) begin
            fin.first_pointer = data_addr;
            if (len > first_len) fin.second_pointer = AW'(data_addr + first_len);
            queue_result(fin);
            return;
        end
        entries = (len - first_len + page - 1) >> sh;
        // no chaining into a second list page
        if (entries > prplb_pkg::MAX_LIST_ENTRIES_DEF) begin
            fin.kind = prplb_pkg::KIND_ERROR;
            queue_result(fin);
            return;
        end
        for (longint unsigned k = 0; k < entries; k++) begin
            slot               = '0;
            slot.kind          = prplb_pkg::KIND_ENTRY;
            slot.entry_address = AW'(list_addr + (k << 3));
            slot.entry_value   = AW'(data_addr + first_len + (k << sh));
            queue_result(slot);
        end
        fin.first_pointer  = data_addr;
        fin.second_pointer = list_addr;
        queue_result(fin);
    endfunction

    // random buffer, weighted toward short lists under the current page shift
    function automatic void make_random_buffer(output logic [AW-1:0] data_addr,
                                               output logic [LW-1:0] len,
                                               output logic [AW-1:0] list_addr);
        int unsigned       page;
        int unsigned       first_len;
        int unsigned       pick;
        int unsigned       pages;
        longint unsigned   want_len;
        page      = 1 << effective_shift();
        data_addr = AW'({$urandom, $urandom});
        list_addr = AW'({$urandom, $urandom});
        // high addresses so page and slot sums wrap
        if ($urandom_range(9) == 0) data_addr[AW-1:24] = '1;
        if ($urandom_range(15) == 0) list_addr[AW-1:12] = '1;
        // most list pages aligned, the rest used as given
        if ($urandom_range(3) != 0) list_addr[11:0] = '0;
        pick = $urandom_range(99);
        if (pick < 5) begin
            len = '0;
        end else if (pick < 33) begin
            len = LW'($urandom_range(2 * page, 1));
        end else if (pick < 88) begin
            // a list needs at least two entries; only a few go long
            pages     = ($urandom_range(7) == 0) ? $urandom_range(63, 9)
                                                 : $urandom_range(8, 2);
            first_len = page - 32'(data_addr[15:0] & 16'(page - 1));
            want_len  = first_len + longint'(pages - 1) * page + $urandom_range(page, 1);
            len       = (want_len > LEN_RANGE_MAX) ? LW'(LEN_RANGE_MAX) : LW'(want_len);
        end else if (pick < 94) begin
            // offset near the page end and the longest lengths: too long at 4 KiB
            data_addr = data_addr | AW'(page - 64);
            len       = LW'($urandom_range(LEN_FIELD_MAX, LEN_RANGE_MAX + 65));
        end else begin
            len = LW'($urandom_range(LEN_FIELD_MAX));
        end
    endfunction

    // offer one buffer, possibly after a random gap; valid stays high on return
    task automatic send_buffer(input logic [AW-1:0] data_addr,
                               input logic [LW-1:0] len,
                               input logic [AW-1:0] list_addr);
        while (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid          <= 1'b1;
        i_buffer_address    <= data_addr;
        i_length_bytes      <= len;
        i_list_page_address <= list_addr;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        predict_prp_results(data_addr, len, list_addr);
    endtask

    // stop offering buffers and wait for every predicted item to come back
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (prp_results_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_page_shift(input logic [SW-1:0] value);
        wait_idle();
        i_cfg_valid      <= 1'b1;
        i_cfg_page_shift <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid    <= 1'b0;
        page_shift_reg = value;
    endtask

    // empty buffers give a final item with zero pointers
    task automatic test_zero_length();
        send_buffer(48'h0000_0001_2340, 18'd0, 48'h0000_0055_6000);
        send_buffer('1, 18'd0, '1);
    endtask

    // buffers within two pages: page edges, exact fits, a wrapping second pointer
    task automatic test_short_buffers();
        send_buffer(48'h0, 18'd1, 48'h0000_0000_9000);
        send_buffer(48'h0000_0000_1000, 18'd4096, 48'h0000_0000_9000);
        send_buffer(48'h0000_0000_1000, 18'd4097, 48'h0000_0000_9000);
        send_buffer(48'h0000_0000_0FFF, 18'd4097, 48'h0000_0000_9000);
        send_buffer(48'h0, 18'd8192, 48'h0000_0000_9000);
        send_buffer('1, 18'd2, 48'h0000_0000_9000);
    endtask

    // list mode: fewest and most entries, wrapping pages and slots, odd list page
    task automatic test_list_entries();
        send_buffer(48'h0, 18'd8193, 48'h0000_0008_0000);
        send_buffer(48'hFFFF_FFFF_F800, 18'd12288, 48'hFFFF_FFFF_FFF0);
        send_buffer(48'h0000_0123_4FFF, 18'd258049, 48'h0000_0567_8000);
        send_buffer(48'h0, 18'd258048, 48'h0000_0ABC_D007);
    endtask

    // one entry past the list page gives the error item
    task automatic test_too_long();
        send_buffer(48'h0000_0123_4FFF, 18'd258050, 48'h0000_0567_8000);
        send_buffer('1, '1, '1);
        send_buffer(48'h0, '1, 48'h0000_0567_8000);
    endtask

    // out of range page shifts act as the nearest supported one
    task automatic test_page_shift_clamp();
        write_page_shift(5'd0);
        send_buffer(48'h0000_0000_1800, 18'h2000, 48'h0000_0002_0000);
        write_page_shift(5'd31);
        send_buffer(48'h0000_0000_8000, 18'd196608, 48'h0000_0002_0000);
        write_page_shift(5'd11);
        send_buffer(48'h0000_0000_0FFF, 18'd8193, 48'h0000_0002_0000);
        write_page_shift(5'd17);
        send_buffer(48'h0000_0001_8000, 18'd140000, 48'h0000_0002_0000);
    endtask

    // random buffers under two page shifts with the given idling
    task automatic test_random_traffic(input int gap_pct, input int hold_pct,
                                       input logic [SW-1:0] shift_a,
                                       input logic [SW-1:0] shift_b);
        logic [AW-1:0] data_addr;
        logic [LW-1:0] len;
        logic [AW-1:0] list_addr;
        send_gap_pct = gap_pct;
        stall_pct    = hold_pct;
        for (int half = 0; half < 2; half++) begin
            write_page_shift(half == 0 ? shift_a : shift_b);
            for (int n = 0; n < ITEMS_PER_SHIFT; n++) begin
                make_random_buffer(data_addr, len, list_addr);
                send_buffer(data_addr, len, list_addr);
            end
        end
    endtask

    function automatic void check_field(input string name, input logic [AW-1:0] want,
                                        input logic [AW-1:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            errors++;
        end
    endfunction

    // result side: outputs are read as they stood at the edge, ready redrawn after
    initial begin : result_checker
        t_prp_result want;
        i_out_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) begin
                if (prp_results_due.size() == 0) begin
                    $error("result item with none expected: kind %0d", o_kind);
                    errors++;
                end else begin
                    want = prp_results_due.pop_front();
                    check_field("kind", AW'(want.kind), AW'(o_kind));
                    check_field("entry_address", want.entry_address, o_entry_address);
                    check_field("entry_value", want.entry_value, o_entry_value);
                    check_field("first_pointer", want.first_pointer, o_first_pointer);
                    check_field("second_pointer", want.second_pointer, o_second_pointer);
                    check_field("last", AW'(want.last), AW'(o_last));
                end
            end
            i_out_ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
        end
    end

    // hard stop if the block hangs
    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("tb: failure");
        $finish;
    end

    initial begin : stimulus
        i_rst_n             = 1'b0;
        i_cfg_valid         = 1'b0;
        i_cfg_page_shift    = '0;
        i_in_valid          = 1'b0;
        i_buffer_address    = '0;
        i_length_bytes      = '0;
        i_list_page_address = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part, no idling: reset page shift, then the clamp test's writes
        test_zero_length();
        test_short_buffers();
        test_list_entries();
        test_too_long();
        test_page_shift_clamp();

        // random part: no idling, sender gaps, receiver stalls, then both
        test_random_traffic(0, 0, 5'd16, 5'd12);
        test_random_traffic(66, 0, 5'd13, 5'd31);
        test_random_traffic(0, 66, 5'd0, 5'd14);
        test_random_traffic(26, 26, 5'd15, 5'd12);

        // let any stray item surface before the verdict
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0 && prp_results_due.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

`default_nettype wire
